### rtl/tmss_pkg.sv
// ----------------------------------------------------------------------------
// tmss_pkg - shared types and constants of the two-mode sample smoother
// Sample, gain and accumulator widths, window size, register map.
// ----------------------------------------------------------------------------
package tmss_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int GAIN_W        = 17;
  localparam int FRAC_W        = 16;
  localparam int ACC_W         = 32;
  localparam int DIFF_W        = ACC_W + 1;
  localparam int PROD_W        = DIFF_W + GAIN_W + 1;

  // Window length must be a power of two (2..256): the average is a shift.
  localparam int WINDOW_LENGTH = 32;
  localparam int WIN_LOG2      = $clog2(WINDOW_LENGTH);
  localparam int WSUM_W        = SAMPLE_W + WIN_LOG2;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32768);

  // APB register map: register i at byte address 4*i
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FILTER_MODE    = 1'b0;
  localparam logic REG_SMOOTHING_GAIN = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  typedef enum logic {
    MODE_EXP = 1'b0,
    MODE_AVG = 1'b1
  } filter_mode_t;

endpackage

### rtl/tmss_exp.sv
// ----------------------------------------------------------------------------
// tmss_exp - first-order exponential smoother
// Q16.16 accumulator moved toward the sample by gain*(x-y), gain in Q1.16.
// ----------------------------------------------------------------------------
module tmss_exp (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tmss_pkg::sample_t sample,
  input  tmss_pkg::gain_t   gain,
  output tmss_pkg::sample_t result
);
  import tmss_pkg::*;

  logic signed [ACC_W-1:0]  smoother_value;
  logic signed [ACC_W-1:0]  smoother_value_next;
  logic        [GAIN_W-1:0] gain_c;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] gain_x;
  logic signed [PROD_W-1:0] diff_x;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    gain_c = (gain > GAIN_ONE) ? GAIN_ONE : gain;
    diff   = $signed({sample[SAMPLE_W-1], sample, {FRAC_W{1'b0}}})
           - $signed({smoother_value[ACC_W-1], smoother_value});
    gain_x = $signed({{(PROD_W-GAIN_W){1'b0}}, gain_c});
    diff_x = $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    prod   = gain_x * diff_x;
    // floor(prod / 2^16), kept modulo the accumulator width
    smoother_value_next = smoother_value + $signed(prod[FRAC_W +: ACC_W]);
  end

  assign result = smoother_value_next[FRAC_W +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      smoother_value <= '0;
    end else if (step) begin
      smoother_value <= smoother_value_next;
    end
  end

endmodule

### rtl/tmss_avg.sv
// ----------------------------------------------------------------------------
// tmss_avg - boxcar moving average
// Shift line of the last WINDOW_LENGTH samples, running sum, floor shift.
// ----------------------------------------------------------------------------
module tmss_avg (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tmss_pkg::sample_t sample,
  output tmss_pkg::sample_t result
);
  import tmss_pkg::*;

  sample_t                  taps [WINDOW_LENGTH];
  logic signed [WSUM_W-1:0] window_sum;
  logic signed [WSUM_W-1:0] window_sum_next;
  sample_t                  oldest;

  assign oldest = taps[WINDOW_LENGTH-1];

  always_comb begin
    window_sum_next = window_sum
                    - $signed({{WIN_LOG2{oldest[SAMPLE_W-1]}}, oldest})
                    + $signed({{WIN_LOG2{sample[SAMPLE_W-1]}}, sample});
  end

  // arithmetic shift by log2 of the window size = floor division by the window size
  assign result = window_sum_next[WIN_LOG2 +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        taps[i] <= '0;
      end
    end else if (step) begin
      window_sum <= window_sum_next;
      taps[0]    <= sample;
      for (int i = 1; i < WINDOW_LENGTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule

### rtl/two_mode_sample_smoother_top.sv
// ----------------------------------------------------------------------------
// two_mode_sample_smoother_top - exponential / moving-average sample smoother
// Path: sample accepted into the input register, then the filter logic
//   feeds the result register once that register is empty or being drained.
// Throughput: one word per cycle while the output is not stalled; both filters
//   update every sample, the exponential loop being one multiply and add.
// Reset (rst, synchronous, active high): filters cleared, filter_mode 0,
//   smoothing_gain 32768, both channels empty. No clearing pass.
// ----------------------------------------------------------------------------
module two_mode_sample_smoother_top (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmss_pkg::ADDR_W-1:0]     paddr,
  input  logic [tmss_pkg::PDATA_W-1:0]    pwdata,
  output logic [tmss_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // sample input channel
  input  tmss_pkg::sample_t               sample_in,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  // smoothed output channel
  output tmss_pkg::sample_t               smoothed_out,
  output logic                            smoothed_valid,
  input  logic                            smoothed_ready
);
  import tmss_pkg::*;

  // configuration registers
  filter_mode_t filter_mode;
  gain_t        smoothing_gain;
  logic         reg_sel;
  logic         cfg_write;

  // input register
  sample_t      sample_reg;
  logic         in_valid;

  // filter results for the word in the input register
  sample_t      exp_result;
  sample_t      avg_result;
  logic         advance;

  // --------------------------------------------------------------------------
  // APB: zero wait states, register picked by paddr[2]
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_sel)
      REG_FILTER_MODE:    prdata = {{(PDATA_W-1){1'b0}}, filter_mode};
      REG_SMOOTHING_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, smoothing_gain};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= MODE_EXP;
      smoothing_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FILTER_MODE:    filter_mode    <= filter_mode_t'(pwdata[0]);
        REG_SMOOTHING_GAIN: smoothing_gain <= pwdata[GAIN_W-1:0];
        default:            ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline: the held word moves into the result register when that
  // register is empty or being drained. Filter state steps on the same edge.
  // --------------------------------------------------------------------------
  assign advance      = in_valid & (~smoothed_valid | smoothed_ready);
  assign sample_ready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ready) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready & sample_valid) begin
      sample_reg <= sample_in;
    end
  end

  tmss_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (sample_reg),
    .gain   (smoothing_gain),
    .result (exp_result)
  );

  tmss_avg u_avg (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (sample_reg),
    .result (avg_result)
  );

  // result register: both filters run, the mode picks the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_valid <= 1'b0;
    end else if (advance) begin
      smoothed_valid <= 1'b1;
    end else if (smoothed_ready) begin
      smoothed_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      smoothed_out <= (filter_mode == MODE_AVG) ? avg_result : exp_result;
    end
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the two-mode sample smoother
// Samples go in through a queued driver and results are checked by a monitor
// against an in-bench model of both filters. Idle gaps and back-pressure are
// random, and the mode and gain are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmss_pkg::*;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam int      RANDOM_WORDS = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side, driven only by the stimulus process
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [ADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // sample and result channels
  sample_t sample_in      = '0;
  logic    sample_valid   = 1'b0;
  logic    sample_ready;
  sample_t smoothed_out;
  logic    smoothed_valid;
  logic    smoothed_ready = 1'b0;

  // words waiting for the driver, and results waiting for the monitor
  sample_t raw_sample_q[$];
  sample_t smoothed_expect_q[$];

  // model copy of the registers and of both filters
  filter_mode_t                 mode_reg;
  gain_t                        gain_reg;
  logic signed [ACC_W-1:0]      ema_acc;
  logic signed [WSUM_W-1:0]     box_sum;
  sample_t                      box_ring[WINDOW_LENGTH];
  logic [WIN_LOG2-1:0]          box_pos;

  int      fail_count = 0;
  int      tx_gap = 0, tx_calm = 0;
  int      rx_stall = 0, rx_calm = 0;
  sample_t want;

  two_mode_sample_smoother_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_in      (sample_in),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .smoothed_out   (smoothed_out),
    .smoothed_valid (smoothed_valid),
    .smoothed_ready (smoothed_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length for either side: mostly none, some short, a few long.
  // Now and then a calm stretch with no idling at all.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One sample through both filters; returns the word of the selected mode.
  // Exponential: acc += floor(gain * (x<<16 - acc) / 2^16), out = floor(acc / 2^16).
  // Boxcar: running sum over the ring, out = floor(sum / WINDOW_LENGTH).
  function automatic sample_t smooth_step(sample_t x);
    gain_t   g;
    longint  diff, adj;
    sample_t y_exp, y_avg;
    // gains above one saturate to one
    g = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    diff = (longint'(x) <<< FRAC_W) - longint'(ema_acc);
    adj = (longint'(g) * diff) >>> FRAC_W;
    ema_acc = ACC_W'(longint'(ema_acc) + adj);
    y_exp = sample_t'(ema_acc >>> FRAC_W);
    // oldest held sample leaves, new one takes its slot
    box_sum = WSUM_W'(int'(box_sum) - int'(box_ring[box_pos]) + int'(x));
    box_ring[box_pos] = x;
    box_pos = box_pos + 1'b1;
    y_avg = sample_t'(box_sum >>> WIN_LOG2);
    return (mode_reg == MODE_AVG) ? y_avg : y_exp;
  endfunction

  // Driver: the model is stepped on every accepted word, so prediction
  // follows the order the block sees. Valid holds until the handshake.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      sample_in    <= '0;
    end else begin
      if (sample_valid && sample_ready)
        smoothed_expect_q.push_back(smooth_step(sample_in));
      if (!sample_valid || sample_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          sample_valid <= 1'b0;
        end else if (raw_sample_q.size() != 0) begin
          sample_in    <= raw_sample_q.pop_front();
          sample_valid <= 1'b1;
          tx_gap = idle_len(tx_calm);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result word is matched against the oldest
  // prediction. Ready drops at random for stalls of varied length.
  always @(posedge clk) begin
    if (rst) begin
      smoothed_ready <= 1'b0;
    end else begin
      if (smoothed_valid && smoothed_ready) begin
        if (smoothed_expect_q.size() == 0) begin
          $error("smoothed_out: word with no expectation, actual %0d", smoothed_out);
          fail_count++;
        end else begin
          want = smoothed_expect_q.pop_front();
          if (smoothed_out !== want) begin
            $error("smoothed_out mismatch: expected %0d, actual %0d", want, smoothed_out);
            fail_count++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        smoothed_ready <= 1'b0;
      end else begin
        smoothed_ready <= 1'b1;
        rx_stall = idle_len(rx_calm);
      end
    end
  end

  // APB write: setup cycle, then access until pready; the model copy
  // follows once the register is written. Only the low bits count.
  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FILTER_MODE)
      mode_reg = filter_mode_t'(value[0]);
    else
      gain_reg = value[GAIN_W-1:0];
  endtask

  // Block is idle once nothing waits to be sent and every result is back.
  // Checked on the falling edge, after the driver and monitor have settled.
  task automatic drain();
    do @(negedge clk);
    while (raw_sample_q.size() != 0 || sample_valid || smoothed_expect_q.size() != 0);
  endtask

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return gain_t'(1);
      2:       return gain_t'(65535);
      3:       return GAIN_ONE;
      4:       return gain_t'($urandom_range(65537, 131071));
      5:       return gain_t'($urandom_range(1, 2048));
      default: return gain_t'($urandom_range(0, 65536));
    endcase
  endfunction

  // Random words in runs of a few shapes: full-range noise, a held extreme
  // long enough to pin the window sum, a held random level, tiny values
  // around zero, and a square wave between the extremes.
  task automatic queue_random_samples(input int count);
    int      kind, run;
    sample_t level;
    while (count > 0) begin
      kind  = $urandom_range(0, 4);
      run   = (kind == 1) ? $urandom_range(32, 48) : $urandom_range(4, 48);
      level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      if (kind == 2) level = sample_t'($urandom);
      if (run > count) run = count;
      for (int k = 0; k < run; k++) begin
        case (kind)
          0:       raw_sample_q.push_back(sample_t'($urandom));
          3:       raw_sample_q.push_back(sample_t'(int'($urandom_range(0, 8)) - 4));
          4:       raw_sample_q.push_back(k[1] ? SAMPLE_MAX : SAMPLE_MIN);
          default: raw_sample_q.push_back(level);
        endcase
      end
      count -= run;
    end
  endtask

  initial begin
    int queued;
    int n;

    // model starts where reset leaves the block
    mode_reg = MODE_EXP;
    gain_reg = GAIN_RESET;
    ema_acc  = '0;
    box_sum  = '0;
    box_pos  = '0;
    foreach (box_ring[i]) box_ring[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings untouched: first word starts from a cleared filter
    raw_sample_q.push_back(SAMPLE_MAX);
    raw_sample_q.push_back(SAMPLE_MIN);
    raw_sample_q.push_back(16'sd0);
    raw_sample_q.push_back(-16'sd1);
    raw_sample_q.push_back(16'sd1);
    raw_sample_q.push_back(16'sh5555);
    drain();

    // boxcar with unity gain running behind it
    write_reg(REG_FILTER_MODE, PDATA_W'(MODE_AVG));
    write_reg(REG_SMOOTHING_GAIN, PDATA_W'(GAIN_ONE));
    repeat (4) raw_sample_q.push_back(SAMPLE_MIN);
    repeat (4) raw_sample_q.push_back(SAMPLE_MAX);
    raw_sample_q.push_back(-16'sd1);
    raw_sample_q.push_back(16'sd1);
    drain();

    // zero gain: the exponential output must not move
    write_reg(REG_FILTER_MODE, PDATA_W'(MODE_EXP));
    write_reg(REG_SMOOTHING_GAIN, '0);
    raw_sample_q.push_back(16'sd12345);
    raw_sample_q.push_back(-16'sd2);
    drain();

    // largest gain code, above one, behaves as one
    write_reg(REG_SMOOTHING_GAIN, PDATA_W'(131071));
    raw_sample_q.push_back(SAMPLE_MAX);
    raw_sample_q.push_back(SAMPLE_MIN);
    raw_sample_q.push_back(16'sd7);
    drain();

    // smallest non-zero gain against full-scale steps
    write_reg(REG_SMOOTHING_GAIN, PDATA_W'(1));
    raw_sample_q.push_back(SAMPLE_MIN);
    raw_sample_q.push_back(SAMPLE_MAX);
    drain();

    // random phases; upper data bits are junk the block has to ignore
    queued = 0;
    while (queued < RANDOM_WORDS) begin
      n = $urandom_range(30, 120);
      write_reg(REG_FILTER_MODE, {31'($urandom), 1'($urandom)});
      write_reg(REG_SMOOTHING_GAIN, {15'($urandom), pick_gain()});
      queue_random_samples(n);
      queued += n;
      drain();
    end

    // run on to catch any stray result word
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
